[design/pfcs_pkg.sv]
// Shared types, constants and the pixel conversion function for the
// pixel format converter / horizontal scaler. No dependencies.
package pfcs_pkg;

  localparam int MAX_LINE  = 4096;
  localparam int RESULT_CAP = 64;

  localparam int PIX_W   = 30;
  localparam int DST_W   = 32;
  localparam int FMT_W   = 4;
  localparam int STEP_W  = 21;
  localparam int COUNT_W = 13;
  localparam int POS_W   = 34;
  localparam int IDX_W   = 17;
  localparam int FRAC_W  = 16;
  localparam int NRES_W  = $clog2(RESULT_CAP) + 1;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = STEP_W;

  // target formats
  localparam logic [FMT_W-1:0] FMT_RGB32  = 4'd0;
  localparam logic [FMT_W-1:0] FMT_BGR32  = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA   = 4'd2;
  localparam logic [FMT_W-1:0] FMT_BGRA   = 4'd3;
  localparam logic [FMT_W-1:0] FMT_RGB24  = 4'd4;
  localparam logic [FMT_W-1:0] FMT_BGR24  = 4'd5;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 4'd6;
  localparam logic [FMT_W-1:0] FMT_BGR565 = 4'd7;
  localparam logic [FMT_W-1:0] FMT_RGB555 = 4'd8;
  localparam logic [FMT_W-1:0] FMT_BGR555 = 4'd9;
  localparam logic [FMT_W-1:0] FMT_RGB332 = 4'd10;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_STEP   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_COUNT  = 2'd2;

  localparam logic [FMT_W-1:0]   FORMAT_RST = FMT_RGB32;
  localparam logic [STEP_W-1:0]  STEP_RST   = 21'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 13'd4096;

  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic             line_start;
  } pix_in_t;

  typedef struct packed {
    logic [DST_W-1:0] dst_pixel;
    logic             line_last;
  } pix_out_t;

  typedef struct packed {
    logic [FMT_W-1:0]   target_format;
    logic [STEP_W-1:0]  step;
    logic [COUNT_W-1:0] out_count;
  } cfg_regs_t;

  typedef struct packed {
    logic start;   // latch the accepted word, clear line state if asked
    logic emit;    // produce one output and advance the position
    logic finish;  // move on to the next source pixel
  } dp_cmd_t;

  typedef struct packed {
    logic more;      // another output belongs to the current source pixel
    logic can_load;  // output register free this cycle
  } dp_stat_t;

  function automatic logic [DST_W-1:0] convert_pixel(
    input logic [PIX_W-1:0] s,
    input logic [FMT_W-1:0] fmt
  );
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [DST_W-1:0] res;
    r = s[27:20];
    g = s[17:10];
    b = s[7:0];
    unique case (fmt) inside
      FMT_RGB32, FMT_RGB24: res = {8'd0, r, g, b};
      FMT_BGR32, FMT_BGR24: res = {8'd0, b, g, r};
      FMT_RGBA:   res = {r, g, b, 8'hff};
      FMT_BGRA:   res = {b, g, r, 8'hff};
      FMT_RGB565: res = {16'd0, r[7:3], g[7:2], b[7:3]};
      FMT_BGR565: res = {16'd0, b[7:3], g[7:2], r[7:3]};
      FMT_RGB555: res = {17'd0, r[7:3], g[7:3], b[7:3]};
      FMT_BGR555: res = {17'd0, b[7:3], g[7:3], r[7:3]};
      FMT_RGB332: res = {24'd0, r[7:5], g[7:5], b[7:6]};
      default:    res = '0;
    endcase
    return res;
  endfunction

endpackage

[design/pfcs_dp.sv]
// Datapath: line position accumulator, counters, conversion and output register.
// Depends on pfcs_pkg.
module pfcs_dp (
  input  logic                clk,
  input  logic                rst,
  input  pfcs_pkg::cfg_regs_t cfg,
  input  pfcs_pkg::pix_in_t   src_data,
  input  pfcs_pkg::dp_cmd_t   cmd,
  output pfcs_pkg::dp_stat_t  stat,
  output logic                dst_valid,
  input  logic                dst_stall,
  output pfcs_pkg::pix_out_t  dst_data
);
  import pfcs_pkg::*;

  logic [PIX_W-1:0]   pixel;
  logic [POS_W-1:0]   position;
  logic [IDX_W-1:0]   source_index;
  logic [COUNT_W-1:0] emitted;
  logic [NRES_W-1:0]  nres;

  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] emitted_next;
  logic [POS_W-1:0]   position_next;

  assign limit = (cfg.out_count > COUNT_W'(MAX_LINE)) ? COUNT_W'(MAX_LINE) : cfg.out_count;
  assign emitted_next  = emitted + COUNT_W'(1);
  assign position_next = position + POS_W'(cfg.step);

  // integer part of the position against the current source pixel
  assign stat.more = !nres[NRES_W-1] && (emitted < limit) &&
                     (position[POS_W-1:FRAC_W] <= {1'b0, source_index});
  assign stat.can_load = !dst_valid || !dst_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      source_index <= '0;
      emitted      <= '0;
      nres         <= '0;
    end else begin
      if (cmd.start) begin
        nres <= '0;
        if (src_data.line_start) begin
          position     <= '0;
          source_index <= '0;
          emitted      <= '0;
        end
      end
      if (cmd.emit) begin
        emitted  <= emitted_next;
        position <= position_next;
        nres     <= nres + NRES_W'(1);
      end
      if (cmd.finish && (source_index != '1)) begin
        source_index <= source_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pixel <= src_data.src_pixel;
    end
  end

  // output register: one word held until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.emit) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dst_data.dst_pixel <= convert_pixel(pixel, cfg.target_format);
      dst_data.line_last <= (emitted_next == limit);
    end
  end

endmodule

[design/pfcs_ctrl.sv]
// Controller: sequences accept, emit and finish steps for one source word.
// Depends on pfcs_pkg.
module pfcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  pfcs_pkg::dp_stat_t stat,
  output pfcs_pkg::dp_cmd_t  cmd
);
  import pfcs_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign src_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (src_valid) begin
          cmd.start  = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.more) begin
          cmd.emit = stat.can_load;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.emit, cmd.finish}))
    else $error("controller issued more than one command");

  a_emit_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (stat.more && stat.can_load))
    else $error("emit without a pending output or a free output register");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !src_stall)
    else $error("source not reopened after finishing a word");

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (src_stall && !cmd.start))
    else $error("new word taken while previous one still in work");

endmodule

[design/pixel_format_convert_scale.sv]
// Top level of the pixel format converter with horizontal scaling.
// Holds the configuration registers; depends on pfcs_pkg, pfcs_ctrl, pfcs_dp.
//
//   channel  handshake            payload
//   src      src_valid/src_stall  src_data  (src_pixel, line_start)
//   dst      dst_valid/dst_stall  dst_data  (dst_pixel, line_last)
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// A source word is taken, then yields N output words (0..64), one at a time;
// then the block steps to the next source pixel and is ready for the next word.
// The emit loop is paced by the single output register; a stalled sink
// holds the loop for as long as it stalls.
// Synchronous reset restores the register defaults and clears the line state.
module pixel_format_convert_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 src_valid,
  output logic                                 src_stall,
  input  pfcs_pkg::pix_in_t                    src_data,
  output logic                                 dst_valid,
  input  logic                                 dst_stall,
  output pfcs_pkg::pix_out_t                   dst_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pfcs_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [pfcs_pkg::CDATA_W-1:0]         cfg_data
);
  import pfcs_pkg::*;

  cfg_regs_t cfg;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_format <= FORMAT_RST;
      cfg.step          <= STEP_RST;
      cfg.out_count     <= COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORMAT: cfg.target_format <= cfg_data[FMT_W-1:0];
        REG_STEP:   cfg.step          <= cfg_data[STEP_W-1:0];
        REG_COUNT:  cfg.out_count     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pfcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_data  (src_data),
    .cmd       (cmd),
    .stat      (stat),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule
